// File: design/bspl_pkg.sv
// ----------------------------------------------------------------------------
// bspl_pkg
// shared types and constants for the partition tree point locator
// ----------------------------------------------------------------------------
package bspl_pkg;

	localparam int MAX_NODES_DEF = 8192;
	localparam int FRACTION_BITS = 16;
	localparam int LINK_W        = 16;
	localparam int LEAF_BIT      = 15;
	localparam int LEAF_W        = 15;
	localparam int COUNT_W       = 14;
	localparam int INDEX_W       = 13;
	localparam int COORD_W       = 32;
	localparam int ENTRY_W       = 4 * COORD_W + 2 * LINK_W;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic                      mode;
		logic [INDEX_W-1:0]        node_index;
		logic signed [COORD_W-1:0] line_x;
		logic signed [COORD_W-1:0] line_y;
		logic signed [COORD_W-1:0] line_dx;
		logic signed [COORD_W-1:0] line_dy;
		logic [LINK_W-1:0]         front_child;
		logic [LINK_W-1:0]         back_child;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} item_t;

	typedef struct packed {
		logic  valid;
		logic  is_query;
		logic  in_range;
		item_t item;
	} queue_head_t;

endpackage

// File: design/bspl_ifs.sv
// ----------------------------------------------------------------------------
// bspl interfaces
// request, response and configuration channels
// ----------------------------------------------------------------------------
interface bspl_req_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      mode;
	logic [bspl_pkg::INDEX_W-1:0]              node_index;
	logic signed [bspl_pkg::COORD_W-1:0]       line_x;
	logic signed [bspl_pkg::COORD_W-1:0]       line_y;
	logic signed [bspl_pkg::COORD_W-1:0]       line_dx;
	logic signed [bspl_pkg::COORD_W-1:0]       line_dy;
	logic [bspl_pkg::LINK_W-1:0]               front_child;
	logic [bspl_pkg::LINK_W-1:0]               back_child;
	logic signed [bspl_pkg::COORD_W-1:0]       point_x;
	logic signed [bspl_pkg::COORD_W-1:0]       point_y;
	modport source (output valid, mode, node_index, line_x, line_y, line_dx, line_dy,
		front_child, back_child, point_x, point_y, input ready);
	modport sink (input valid, mode, node_index, line_x, line_y, line_dx, line_dy,
		front_child, back_child, point_x, point_y, output ready);
endinterface

interface bspl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bspl_pkg::LEAF_W-1:0]   leaf_index;
	logic                          walk_error;
	modport source (output valid, leaf_index, walk_error, input ready);
	modport sink (input valid, leaf_index, walk_error, output ready);
endinterface

interface bspl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bspl_pkg::COUNT_W-1:0]   node_count;
	modport source (output valid, node_count, input ready);
	modport sink (input valid, node_count, output ready);
endinterface

// File: design/bspl_ram.sv
// ----------------------------------------------------------------------------
// bspl_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module bspl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: design/bspl_front.sv
// ----------------------------------------------------------------------------
// bspl_front
// accepts items, classifies them and holds them in a two entry queue
// ----------------------------------------------------------------------------
module bspl_front #(
	parameter int MAX_NODES = bspl_pkg::MAX_NODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bspl_req_if.sink             req,
	output bspl_pkg::queue_head_t head,
	input  logic                 pop
);
	bspl_pkg::item_t    ent_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;
	bspl_pkg::item_t    in_item;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;

	always_comb begin
		in_item.mode        = req.mode;
		in_item.node_index  = req.node_index;
		in_item.line_x      = req.line_x;
		in_item.line_y      = req.line_y;
		in_item.line_dx     = req.line_dx;
		in_item.line_dy     = req.line_dy;
		in_item.front_child = req.front_child;
		in_item.back_child  = req.back_child;
		in_item.point_x     = req.point_x;
		in_item.point_y     = req.point_y;
	end

	always_comb begin
		head.valid    = (cnt_q != 2'd0);
		head.item     = ent_q[rd_ptr_q];
		head.is_query = (ent_q[rd_ptr_q].mode == bspl_pkg::MODE_QUERY);
		head.in_range = ({3'b0, ent_q[rd_ptr_q].node_index} < 16'(MAX_NODES));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !req.ready) else $error("ready while full");
`endif
endmodule

// File: design/bspl_walk.sv
// ----------------------------------------------------------------------------
// bspl_walk
// stores node writes, walks tree levels for queries by read, multiply, select
// ----------------------------------------------------------------------------
module bspl_walk #(
	parameter int MAX_NODES = bspl_pkg::MAX_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bspl_pkg::queue_head_t          head,
	output logic                           pop,
	input  logic [bspl_pkg::COUNT_W-1:0]   node_count,
	bspl_rsp_if.source                     rsp
);
	localparam int AW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_NODES + 1);
	localparam int CW = bspl_pkg::COORD_W;
	localparam int LW = bspl_pkg::LINK_W;
	localparam int FB = bspl_pkg::FRACTION_BITS;
	localparam int PW = CW + CW - FB;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_SEL, S_DONE} state_t;

	state_t                 state_q;
	logic [LW-1:0]          cur_q;
	logic [SW-1:0]          steps_q;
	logic signed [CW-1:0]   px_q, py_q;
	logic                   early_q, eside_q;
	logic signed [PW-1:0]   lhs_s2, rhs_s2;
	logic [bspl_pkg::LEAF_W-1:0] res_leaf_q;
	logic                   res_err_q;
	logic                   out_valid_q;
	logic [bspl_pkg::LEAF_W-1:0] out_leaf_q;
	logic                   out_err_q;

	logic                   we, re;
	logic [bspl_pkg::ENTRY_W-1:0] wdata, rdata;
	logic [AW-1:0]          waddr;
	logic [LW-1:0]          cnt_sat, root;

	logic signed [CW-1:0]   ox, oy, dx, dy, rx, ry;
	logic [LW-1:0]          front_l, back_l, nxt;
	logic                   eside, early, side;
	logic [SW-1:0]          steps_nx;
	logic                   load_out;

	bspl_ram #(.WIDTH(bspl_pkg::ENTRY_W), .DEPTH(MAX_NODES)) u_ram (
		.clk, .we, .waddr, .wdata, .re, .raddr(cur_q[AW-1:0]), .rdata
	);

	assign waddr = AW'({3'b0, head.item.node_index});
	assign wdata = {head.item.back_child, head.item.front_child, head.item.line_dy,
		head.item.line_dx, head.item.line_y, head.item.line_x};
	assign pop   = (state_q == S_IDLE) && head.valid;
	assign we    = pop && !head.is_query && head.in_range;
	assign re    = (state_q == S_RD);

	assign cnt_sat = ({2'b0, node_count} > LW'(MAX_NODES)) ? LW'(MAX_NODES)
		: {2'b0, node_count};
	assign root    = cnt_sat - 1'b1;

	assign ox      = rdata[CW-1:0];
	assign oy      = rdata[2*CW-1:CW];
	assign dx      = rdata[3*CW-1:2*CW];
	assign dy      = rdata[4*CW-1:3*CW];
	assign front_l = rdata[4*CW+LW-1:4*CW];
	assign back_l  = rdata[4*CW+2*LW-1:4*CW+LW];
	assign rx      = px_q - ox;
	assign ry      = py_q - oy;

	always_comb begin
		early = 1'b1;
		if (dx == '0) begin
			eside = (px_q <= ox) ? (dy > 0) : (dy < 0);
		end else if (dy == '0) begin
			eside = (py_q <= oy) ? (dx < 0) : (dx > 0);
		end else if (dy[CW-1] ^ dx[CW-1] ^ rx[CW-1] ^ ry[CW-1]) begin
			eside = dy[CW-1] ^ rx[CW-1];
		end else begin
			early = 1'b0;
			eside = 1'b0;
		end
	end

	assign side     = early_q ? eside_q
		: ($signed(lhs_s2[PW-1:FB]) >= $signed(rhs_s2[PW-1:FB]));
	assign nxt      = side ? back_l : front_l;
	assign steps_nx = steps_q + 1'b1;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q    <= head.item.point_x;
				py_q    <= head.item.point_y;
				cur_q   <= root;
				steps_q <= '0;
				res_leaf_q <= '0;
				res_err_q  <= 1'b0;
			end
			S_MUL: begin
				early_q <= early;
				eside_q <= eside;
				lhs_s2  <= PW'(ry) * PW'($signed(dx[CW-1:FB]));
				rhs_s2  <= PW'($signed(dy[CW-1:FB])) * PW'(rx);
			end
			S_SEL: begin
				cur_q   <= nxt;
				steps_q <= steps_nx;
				if (nxt[bspl_pkg::LEAF_BIT]) begin
					res_leaf_q <= nxt[bspl_pkg::LEAF_W-1:0];
					res_err_q  <= 1'b0;
				end else begin
					res_leaf_q <= '0;
					res_err_q  <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && head.is_query) begin
						state_q <= (cnt_sat == '0) ? S_DONE : S_RD;
					end
				end
				S_RD: state_q <= S_MUL;
				S_MUL: state_q <= S_SEL;
				S_SEL: begin
					if (nxt[bspl_pkg::LEAF_BIT] || nxt >= LW'(MAX_NODES)
						|| steps_nx >= SW'(MAX_NODES)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_leaf_q <= res_leaf_q;
			out_err_q  <= res_err_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.leaf_index = out_leaf_q;
	assign rsp.walk_error = out_err_q;

`ifndef ASSERT_OFF
	a_rd_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (!cur_q[bspl_pkg::LEAF_BIT] && cur_q < LW'(MAX_NODES)))
		else $error("read of leaf or out of range node");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (steps_q < SW'(MAX_NODES))) else $error("walk too long");
	a_err_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_leaf_q == '0)) else $error("error with leaf");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> ($past(head.is_query) || state_q == S_IDLE)) else $error("write left idle");
`endif
endmodule

// File: design/bsp_point_location.sv
// ----------------------------------------------------------------------------
// bsp_point_location
// partition tree node table and point locator
// ----------------------------------------------------------------------------
// req carries node writes (mode 0) and point queries (mode 1); each transfer
// on req with mode 1 gives exactly one transfer on rsp, writes give none.
// cfg sets node_count; write it only while no query is in flight.
// A two entry queue sits behind req, so req keeps taking items while the
// walker works. Writes are taken from the queue head while the walker is
// idle. A query walks the tree one level at a time through the single
// table read port, each level a table read, a multiply and a select.
// Results wait in an output register; while rsp is stalled the walker holds
// a finished result and the queue fills, then req drops ready.
// Reset clears control state and node_count; the node table is not cleared
// and must be written before it is walked.
// ----------------------------------------------------------------------------
module bsp_point_location #(
	parameter int MAX_NODES = bspl_pkg::MAX_NODES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bspl_req_if.sink   req,
	bspl_rsp_if.source rsp,
	bspl_cfg_if.sink   cfg
);
	logic [bspl_pkg::COUNT_W-1:0] node_count_q;
	bspl_pkg::queue_head_t        head;
	logic                         pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg.valid) begin
			node_count_q <= cfg.node_count;
		end
	end

	bspl_front #(.MAX_NODES(MAX_NODES)) u_front (
		.clk, .arst_n, .req, .head, .pop
	);

	bspl_walk #(.MAX_NODES(MAX_NODES)) u_walk (
		.clk, .arst_n, .head, .pop, .node_count(node_count_q), .rsp
	);
endmodule
